### src/ili_pkg.sv
// shared types and codes for the inverse linear interpolation block
`default_nettype none

package ili_pkg;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FLAT = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // request kinds carried on tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_SRCH_RD  = 10'b00_0000_0010,
        S_SRCH_CMP = 10'b00_0000_0100,
        S_RD_LO    = 10'b00_0000_1000,
        S_RD_HI    = 10'b00_0001_0000,
        S_PREP     = 10'b00_0010_0000,
        S_SETUP    = 10'b00_0100_0000,
        S_DIV      = 10'b00_1000_0000,
        S_MUL      = 10'b01_0000_0000,
        S_FIN      = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

### src/inverse_linear_interpolation.sv
// top level: breakpoint table memories, binary search, serial divide and multiply
//
// Inverse piecewise-linear lookup. The block keeps a table of (x, y) breakpoints
// in two synchronous memories (one for x, one for y, each with a registered read).
// A write request (tuser = 0) stores entry_x and entry_y at entry_index and gives
// no result; an index at or beyond TABLE_DEPTH is dropped.
// A query request (tuser = 1) carries query_y and gives one result: the x at which
// the bracketing segment's line reaches query_y, signed Q16.16 by default, with
// status 0 ok, 1 flat segment (lower x returned), 2 saturated. Queries outside the
// table extrapolate along the end segment. One request is worked on at a time;
// the input is ready again once the result is loaded into the output register.
// A flat segment skips the divide and multiply. The time a query takes is set
// by the memory read per search step, the one-bit-per-cycle restoring divider
// and the shift-add multiplier. The finished result sits in an output register,
// so a new request is taken while it waits. There is no clearing pass: entries
// read before being written return whatever the memory holds. last_index is to
// be written through i_cfg_we / i_cfg_wdata only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

module inverse_linear_interpolation
    import ili_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration: last_index
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_wdata,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // entry_index[7:0], entry_x[39:8], entry_y[71:40], query_y[103:72]
    input  wire logic [103:0] s_axis_tdata,
    // req_type[0]
    input  wire logic [0:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // x_result[31:0], status[33:32], zero fill above
    output logic [39:0]       m_axis_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW = 32 + FRAC_BITS;   // dividend / quotient width
    localparam int PW = 64 + FRAC_BITS;   // product width
    localparam int CW = $clog2(DW);
    localparam logic [PW-1:0] LIMIT = PW'(1) << (33 + FRAC_BITS);

    // state and datapath registers
    t_state            r_state;
    logic [7:0]        r_last;
    logic [AW-1:0]     r_lo;
    logic [AW-1:0]     r_hi;
    logic [AW-1:0]     r_mid;
    logic [31:0]       r_yq;
    logic [31:0]       r_xlo;
    logic [31:0]       r_ylo;
    logic [32:0]       r_num;
    logic [32:0]       r_den;
    logic [32:0]       r_dx;
    logic              r_neg;
    logic              r_flat;
    logic [31:0]       r_aden;
    logic [31:0]       r_adx;
    logic [31:0]       r_rem;
    logic [DW-1:0]     r_quo;
    logic [CW-1:0]     r_cnt;
    logic [PW-1:0]     r_mcand;
    logic [31:0]       r_mplier;
    logic [PW-1:0]     r_acc;
    logic              r_out_valid;
    logic [31:0]       r_out_x;
    logic [1:0]        r_out_status;

    // table memories and their registered read data
    logic [31:0]       x_mem [TABLE_DEPTH];
    logic [31:0]       y_mem [TABLE_DEPTH];
    logic [31:0]       r_x_rd;
    logic [31:0]       r_y_rd;

    // request fields
    logic              w_in_acc;
    logic [7:0]        w_idx;
    logic [31:0]       w_ex;
    logic [31:0]       w_ey;
    logic [31:0]       w_qy;
    logic [31:0]       w_idx32;
    logic              w_wr_en;
    logic [31:0]       w_last32;
    logic [AW-1:0]     w_hi0;
    logic [AW:0]       w_sum;
    logic [AW-1:0]     w_mid;
    logic [AW-1:0]     w_span;
    logic [AW-1:0]     w_rd_addr;

    // arithmetic helpers
    logic [32:0]       w_num;
    logic [32:0]       w_den;
    logic [32:0]       w_dx;
    logic [32:0]       w_anum33;
    logic [32:0]       w_aden33;
    logic [32:0]       w_adx33;
    logic [32:0]       w_trial;
    logic              w_qbit;
    logic [31:0]       w_rem_nx;
    logic [DW-1:0]     w_quo_nx;
    logic              w_psat;
    logic [33:0]       w_dmag;
    logic [34:0]       w_xe;
    logic [34:0]       w_res;
    logic [31:0]       w_res_x;
    logic [1:0]        w_res_st;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_idx    = s_axis_tdata[7:0];
    assign w_ex     = s_axis_tdata[39:8];
    assign w_ey     = s_axis_tdata[71:40];
    assign w_qy     = s_axis_tdata[103:72];
    assign w_idx32  = {24'd0, w_idx};
    assign w_wr_en  = w_in_acc && (s_axis_tuser[0] == REQ_WRITE)
                      && (w_idx32 < 32'(TABLE_DEPTH));

    // upper bracket starts at last_index, clamped to the table
    assign w_last32 = {24'd0, r_last};
    assign w_hi0    = (w_last32 > 32'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                         : w_last32[AW-1:0];
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[AW:1];
    assign w_span   = r_hi - r_lo;

    always_comb begin
        case (r_state)
            S_SRCH_RD: w_rd_addr = w_mid;
            S_RD_LO:   w_rd_addr = r_lo;
            S_RD_HI:   w_rd_addr = r_hi;
            default:   w_rd_addr = r_mid;
        endcase
    end

    // segment differences, all exact in 33 bits
    assign w_num    = {r_yq[31], r_yq} - {r_ylo[31], r_ylo};
    assign w_den    = {r_y_rd[31], r_y_rd} - {r_ylo[31], r_ylo};
    assign w_dx     = {r_x_rd[31], r_x_rd} - {r_xlo[31], r_xlo};
    assign w_anum33 = r_num[32] ? (~r_num + 33'd1) : r_num;
    assign w_aden33 = r_den[32] ? (~r_den + 33'd1) : r_den;
    assign w_adx33  = r_dx[32]  ? (~r_dx + 33'd1)  : r_dx;

    // restoring divider step
    assign w_trial  = {r_rem, r_quo[DW-1]};
    assign w_qbit   = (w_trial >= {1'b0, r_aden});
    assign w_rem_nx = w_qbit ? 32'(w_trial - {1'b0, r_aden}) : w_trial[31:0];
    assign w_quo_nx = {r_quo[DW-2:0], w_qbit};

    // final add and clamp
    assign w_psat = (r_acc > LIMIT);
    assign w_dmag = r_acc[FRAC_BITS +: 34];
    assign w_xe   = {{3{r_xlo[31]}}, r_xlo};
    assign w_res  = r_neg ? (w_xe - {1'b0, w_dmag}) : (w_xe + {1'b0, w_dmag});

    always_comb begin
        if (r_flat) begin
            w_res_x  = r_xlo;
            w_res_st = ST_FLAT;
        end else if (w_psat) begin
            w_res_x  = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            w_res_st = ST_SAT;
        end else if ($signed(w_res) > $signed(35'sh0_7FFF_FFFF)) begin
            w_res_x  = 32'h7FFF_FFFF;
            w_res_st = ST_SAT;
        end else if ($signed(w_res) < -$signed(35'sh0_8000_0000)) begin
            w_res_x  = 32'h8000_0000;
            w_res_st = ST_SAT;
        end else begin
            w_res_x  = w_res[31:0];
            w_res_st = ST_OK;
        end
    end

    // memories: one write and one read address per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            x_mem[w_idx32[AW-1:0]] <= w_ex;
            y_mem[w_idx32[AW-1:0]] <= w_ey;
        end
        r_x_rd <= x_mem[w_rd_addr];
        r_y_rd <= y_mem[w_rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 8'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_last <= i_cfg_wdata;
            end
            // the final step reloads the output itself
            if (r_out_valid && m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (s_axis_tuser[0] == REQ_QUERY)) begin
                        r_lo    <= '0;
                        r_hi    <= w_hi0;
                        r_yq    <= w_qy;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    // one halving per read of y[mid]
                    if (w_span > AW'(1)) begin
                        r_mid   <= w_mid;
                        r_state <= S_SRCH_CMP;
                    end else begin
                        r_state <= S_RD_LO;
                    end
                end
                S_SRCH_CMP: begin
                    if ($signed(r_y_rd) > $signed(r_yq)) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid;
                    end
                    r_state <= S_SRCH_RD;
                end
                S_RD_LO: begin
                    r_state <= S_RD_HI;
                end
                S_RD_HI: begin
                    r_xlo   <= r_x_rd;
                    r_ylo   <= r_y_rd;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_num   <= w_num;
                    r_den   <= w_den;
                    r_dx    <= w_dx;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_neg  <= r_num[32] ^ r_den[32] ^ r_dx[32];
                    r_aden <= w_aden33[31:0];
                    r_adx  <= w_adx33[31:0];
                    r_rem  <= '0;
                    r_quo  <= DW'({w_anum33[31:0], {FRAC_BITS{1'b0}}});
                    r_cnt  <= CW'(DW - 1);
                    r_acc  <= '0;
                    if (r_den == 33'd0) begin
                        r_flat  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_flat  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_nx;
                    r_quo <= w_quo_nx;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        r_mcand  <= PW'(w_quo_nx);
                        r_mplier <= r_adx;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    // shift-add, stops once the multiplier runs out of ones
                    if (r_mplier == 32'd0) begin
                        r_state <= S_FIN;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_x      <= w_res_x;
                        r_out_status <= w_res_st;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status, r_out_x};

    // the search bracket always spans more than one entry when probed
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CMP) |-> (r_lo < r_mid) && (r_mid < r_hi))
        else $error("search probe outside bracket");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_aden != 32'd0))
        else $error("divide by zero entered");

    // a result appears only from the final step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside final step");

    // a flat segment always reports the flat status
    a_flat_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && r_flat |-> (w_res_st == ST_FLAT))
        else $error("flat segment lost its status");

endmodule

`default_nettype wire
